// ===== rtl/core/kmscm_pkg.sv =====
package kmscm_pkg;

  // Default geometry of the key matrix and the map table
  localparam int ROWS_DEF      = 6;
  localparam int COLUMNS_DEF   = 5;
  localparam int MAP_DEPTH_DEF = 32;

  // Fixed field widths
  localparam int COL_LEVEL_W = 5;
  localparam int ENTRY_IDX_W = 5;
  localparam int KEY_MASK_W  = 30;
  localparam int CMD_W       = 8;
  localparam int ROW_OUT_W   = 3;
  localparam int LED_W       = 5;
  localparam int USED_W      = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANCEL_COMMAND   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENTRIES_USED = 1'd1;

  // Input action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Source of the command field of a result
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_HELD,
    SEL_CANCEL
  } out_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     take;       // input request accepted this cycle
    logic     rd_start;   // rewind the map table walk
    logic     rd_step;    // read the next map entry
    logic     held_load;  // keep the entry just read as pending command
    logic     out_load;   // load the output register
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;           // entry read last shares a bit with the new presses
    logic more;          // entries left to walk
    logic pressed_any;
    logic released_any;
  } sts_t;

endpackage

// ===== rtl/core/kmscm_ctrl.sv =====
module kmscm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_action,
  output logic            in_tready,
  input  logic            out_tready,
  output logic            out_tvalid,
  output kmscm_pkg::cmd_t cmd_o,
  input  kmscm_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   held_r, held_nxt;
  logic   rd_pend_r, rd_pend_nxt;
  logic   out_free;
  logic   hit;
  logic   stall;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign hit        = rd_pend_r && sts_i.hit;
  assign stall      = hit && held_r && !out_free;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    held_nxt        = held_r;
    rd_pend_nxt     = rd_pend_r;
    cmd_o           = '0;
    cmd_o.out_sel   = kmscm_pkg::SEL_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_o.take     = 1'b1;
          cmd_o.rd_start = 1'b1;
          held_nxt       = 1'b0;
          rd_pend_nxt    = 1'b0;
          state_nxt      = (in_action == kmscm_pkg::ACT_WRITE) ? ST_DRAIN : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!stall) begin
          cmd_o.rd_step = sts_i.more && sts_i.pressed_any;
          rd_pend_nxt   = sts_i.more && sts_i.pressed_any;
          if (hit) begin
            // a newer hit pushes the pending one out; it cannot be the last
            if (held_r) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = kmscm_pkg::SEL_HELD;
            end
            cmd_o.held_load = 1'b1;
            held_nxt        = 1'b1;
          end
          if (!rd_pend_r && !(sts_i.more && sts_i.pressed_any)) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.released_any && held_r) begin
            cmd_o.out_sel = kmscm_pkg::SEL_HELD;
            held_nxt      = 1'b0;
          end else if (sts_i.released_any) begin
            cmd_o.out_sel  = kmscm_pkg::SEL_CANCEL;
            cmd_o.out_last = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (held_r) begin
            cmd_o.out_sel  = kmscm_pkg::SEL_HELD;
            cmd_o.out_last = 1'b1;
            held_nxt       = 1'b0;
            state_nxt      = ST_IDLE;
          end else begin
            cmd_o.out_sel  = kmscm_pkg::SEL_NONE;
            cmd_o.out_last = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  // A result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // No pending command survives into the next request
  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !held_r)
    else $error("pending command left behind");

  // Map reads are only in flight during the walk
  a_read_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SEARCH))
    else $error("map read outstanding outside the walk");

  // A table write goes straight to its single result
  a_write_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.take && (in_action == kmscm_pkg::ACT_WRITE)) |=> (state_r == ST_DRAIN))
    else $error("table write did not go to result");

endmodule

// ===== rtl/core/kmscm_dp.sv =====
module kmscm_dp #(
  parameter int ROWS      = kmscm_pkg::ROWS_DEF,
  parameter int COLUMNS   = kmscm_pkg::COLUMNS_DEF,
  parameter int MAP_DEPTH = kmscm_pkg::MAP_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [kmscm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kmscm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_action,
  input  logic [kmscm_pkg::COL_LEVEL_W-1:0]    in_column_levels,
  input  logic [kmscm_pkg::ENTRY_IDX_W-1:0]    in_entry_index,
  input  logic [kmscm_pkg::KEY_MASK_W-1:0]     in_entry_key_mask,
  input  logic [kmscm_pkg::CMD_W-1:0]          in_entry_command,
  input  kmscm_pkg::cmd_t                      cmd_i,
  output kmscm_pkg::sts_t                      sts_o,
  output logic [kmscm_pkg::ROW_OUT_W-1:0]      out_row_drive,
  output logic [kmscm_pkg::LED_W-1:0]          out_led_columns,
  output logic                                 out_command_valid,
  output logic [kmscm_pkg::CMD_W-1:0]          out_command_byte,
  output logic                                 out_last
);

  localparam int KEY_BITS = ROWS * COLUMNS;
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CW       = $clog2(MAP_DEPTH + 1);

  // Key state and configuration
  logic [ROWS-1:0][COLUMNS-1:0]      cur_r, acc_r, cur_nxt;
  logic [RW-1:0]                     scan_row_r, row_next, row_sel;
  logic [kmscm_pkg::CMD_W-1:0]       cancel_r;
  logic [kmscm_pkg::USED_W-1:0]      used_r;
  logic [KEY_BITS-1:0]               pressed_r;
  logic                              released_r;

  // Result fields captured at accept
  logic [RW-1:0]                     res_row_r;
  logic [COLUMNS-1:0]                res_leds_r;

  // Map table and walk
  logic [KEY_BITS-1:0]               mask_mem [MAP_DEPTH];
  logic [kmscm_pkg::CMD_W-1:0]       cmd_mem  [MAP_DEPTH];
  logic [KEY_BITS-1:0]               rd_mask_r;
  logic [kmscm_pkg::CMD_W-1:0]       rd_cmd_r;
  logic [kmscm_pkg::CMD_W-1:0]       held_cmd_r;
  logic [CW-1:0]                     cnt_r;
  logic [CW-1:0]                     used_eff;

  logic [7:0]                        cols8;
  logic [5:0]                        idx6;
  logic [63:0]                       mask64;
  logic [7:0]                        row8;
  logic [7:0]                        leds8;
  logic                              wr_ok;

  // Column sample, active low, cut to the matrix width
  assign cols8 = {3'b000, ~in_column_levels};

  assign row_next = (scan_row_r == RW'(ROWS - 1)) ? '0 : scan_row_r + 1'b1;
  assign row_sel  = (in_action == kmscm_pkg::ACT_WRITE) ? scan_row_r : row_next;

  always_comb begin
    cur_nxt             = cur_r;
    cur_nxt[scan_row_r] = cols8[COLUMNS-1:0];
  end

  // Table write decode
  assign idx6   = {1'b0, in_entry_index};
  assign wr_ok  = idx6 < 6'(MAP_DEPTH);
  assign mask64 = 64'(in_entry_key_mask);

  // Number of entries walked, bounded by the table size
  assign used_eff = (used_r > 6'(MAP_DEPTH)) ? CW'(MAP_DEPTH) : used_r[CW-1:0];

  assign sts_o.hit          = |(rd_mask_r & pressed_r);
  assign sts_o.more         = cnt_r < used_eff;
  assign sts_o.pressed_any  = |pressed_r;
  assign sts_o.released_any = released_r;

  assign row8  = 8'(res_row_r);
  assign leds8 = 8'(res_leds_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cancel_r <= '0;
      used_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        kmscm_pkg::CFG_CANCEL_COMMAND:   cancel_r <= cfg_data;
        kmscm_pkg::CFG_MAP_ENTRIES_USED: used_r   <= cfg_data[kmscm_pkg::USED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Key vectors, scan row and change detection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      acc_r      <= '0;
      scan_row_r <= '0;
      pressed_r  <= '0;
      released_r <= 1'b0;
    end else if (cmd_i.take) begin
      if (in_action == kmscm_pkg::ACT_WRITE) begin
        pressed_r  <= '0;
        released_r <= 1'b0;
      end else begin
        scan_row_r <= row_next;
        cur_r      <= cur_nxt;
        acc_r      <= cur_nxt;
        pressed_r  <= cur_nxt & ~acc_r;
        released_r <= |(acc_r & ~cur_nxt);
      end
    end
  end

  // Row and LED bits use the accepted vector from before the update
  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      res_row_r  <= row_sel;
      res_leds_r <= acc_r[row_sel];
    end
  end

  // Map table memory
  always_ff @(posedge clk) begin
    if (cmd_i.take && (in_action == kmscm_pkg::ACT_WRITE) && wr_ok) begin
      mask_mem[idx6[AW-1:0]] <= mask64[KEY_BITS-1:0];
      cmd_mem[idx6[AW-1:0]]  <= in_entry_command;
    end
    if (cmd_i.rd_step) begin
      rd_mask_r <= mask_mem[cnt_r[AW-1:0]];
      rd_cmd_r  <= cmd_mem[cnt_r[AW-1:0]];
    end
  end

  // Walk counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd_i.rd_start) begin
      cnt_r <= '0;
    end else if (cmd_i.rd_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Pending command and output register
  always_ff @(posedge clk) begin
    if (cmd_i.held_load) begin
      held_cmd_r <= rd_cmd_r;
    end
    if (cmd_i.out_load) begin
      out_row_drive   <= row8[kmscm_pkg::ROW_OUT_W-1:0];
      out_led_columns <= leds8[kmscm_pkg::LED_W-1:0];
      out_last        <= cmd_i.out_last;
      case (cmd_i.out_sel)
        kmscm_pkg::SEL_HELD: begin
          out_command_valid <= 1'b1;
          out_command_byte  <= held_cmd_r;
        end
        kmscm_pkg::SEL_CANCEL: begin
          out_command_valid <= 1'b1;
          out_command_byte  <= cancel_r;
        end
        default: begin
          out_command_valid <= 1'b0;
          out_command_byte  <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/keypad_matrix_scan_command_map.sv =====
// Key matrix scanner with command map. Each scan tick on the input stream
// (tuser 0) carries the active-low column levels of the row driven now; the
// block stores them in its key vector, steps to the next row and reports that
// row and its LED bits. When keys change, newly pressed keys are matched
// against map entries 0 to min(map_entries_used, MAP_DEPTH) - 1 in order,
// one result per matching entry, then one cancel result if any key was
// released; a tick with no command gives a single result with tuser 0. A
// table write (tuser 1) loads one map entry and gives one such result. tlast
// marks the final result of a request. The map memory has a single read port
// and is walked one entry per cycle unless a result not yet taken holds the
// walk; a new request is taken only after the last one ends. Configuration
// must be written only while idle; the block itself does not enforce it.
module keypad_matrix_scan_command_map #(
  parameter int ROWS      = kmscm_pkg::ROWS_DEF,
  parameter int COLUMNS   = kmscm_pkg::COLUMNS_DEF,
  parameter int MAP_DEPTH = kmscm_pkg::MAP_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kmscm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmscm_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: column_levels[4:0], entry_index[9:5], entry_key_mask[39:10],
  //        entry_command[47:40]
  input  logic [47:0]                      in_tdata,
  // tuser: action[0]
  input  logic                             in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: row_drive[2:0], led_columns[7:3], command_byte[15:8]
  output logic [15:0]                      out_tdata,
  // tuser: command_valid[0]
  output logic                             out_tuser,
  output logic                             out_tlast
);

  kmscm_pkg::cmd_t cmd;
  kmscm_pkg::sts_t sts;

  logic [kmscm_pkg::ROW_OUT_W-1:0] row_drive;
  logic [kmscm_pkg::LED_W-1:0]     led_columns;
  logic [kmscm_pkg::CMD_W-1:0]     command_byte;

  assign cfg_ready = 1'b1;
  assign out_tdata = {command_byte, led_columns, row_drive};

  kmscm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  kmscm_dp #(
    .ROWS      (ROWS),
    .COLUMNS   (COLUMNS),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_action         (in_tuser),
    .in_column_levels  (in_tdata[4:0]),
    .in_entry_index    (in_tdata[9:5]),
    .in_entry_key_mask (in_tdata[39:10]),
    .in_entry_command  (in_tdata[47:40]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_row_drive     (row_drive),
    .out_led_columns   (led_columns),
    .out_command_valid (out_tuser),
    .out_command_byte  (command_byte),
    .out_last          (out_tlast)
  );

endmodule
